// File: rtl/core/assert_macros.svh
// Assertion macros used by the back part of the replacement engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lipv_pkg.sv
// Package with the types and constants of the recency stack replacement engine.
`timescale 1ns / 1ps
`default_nettype none

package lipv_pkg;

    localparam int unsigned WAY_W      = 4;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned SET_IN_W   = 6;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned PROMOTE_W  = 2 * DATA_W;

    localparam int unsigned WAYS_DEFAULT = 16;
    localparam int unsigned SETS_DEFAULT = 64;
    localparam int unsigned CMD_DEPTH    = 2;
    localparam int unsigned RES_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PROMOTE_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROMOTE_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INSERT_POSITION = 2'd2;

    localparam logic [DATA_W-1:0] PROMOTE_LOW_RESET  = 32'h2103_0100;
    localparam logic [DATA_W-1:0] PROMOTE_HIGH_RESET = 32'hB100_1501;
    localparam logic [POS_W-1:0]  INSERT_RESET       = 4'd13;

    typedef enum logic [1:0] {
        OP_HIT   = 2'd0,
        OP_FILL  = 2'd1,
        OP_INVAL = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [WAY_W-1:0] way;
    } cmd_t;

    typedef struct packed {
        logic [WAY_W-1:0] victim_way;
        logic [POS_W-1:0] old_position;
    } res_t;

    typedef struct packed {
        logic [PROMOTE_W-1:0] promote;
        logic [POS_W-1:0]     insert_position;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_FETCH,
        BK_EXEC
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/lipv_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lipv_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/lipv_fifo.sv
// Small first-in first-out queue with the head word shown while not empty.
`timescale 1ns / 1ps
`default_nettype none

module lipv_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lipv_front.sv
// Front part: accepts request words, maps the set and classifies the operation.
`timescale 1ns / 1ps
`default_nettype none

module lipv_front #(
    parameter int unsigned WAYS  = lipv_pkg::WAYS_DEFAULT,
    parameter int unsigned SETS  = lipv_pkg::SETS_DEFAULT,
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [1:0]                    mode,
    input  wire logic [lipv_pkg::SET_IN_W-1:0] set_number,
    input  wire logic [lipv_pkg::WAY_W-1:0]    way,
    input  wire logic                          clearing,
    output logic                               full,
    input  wire logic                          cmd_pop,
    output logic                               cmd_empty,
    output lipv_pkg::cmd_t                     cmd_head,
    output logic      [SET_W-1:0]              cmd_set
);

    localparam int unsigned SET_IN_N = 2 ** lipv_pkg::SET_IN_W;
    localparam int unsigned Q_W      = SET_W + $bits(lipv_pkg::cmd_t);
    localparam logic [lipv_pkg::WAY_W:0] WAYS_V = (lipv_pkg::WAY_W + 1)'(WAYS);

    logic [SET_W-1:0] set_map [SET_IN_N];
    lipv_pkg::cmd_t   cmd_in;
    logic [Q_W-1:0]   q_wdata, q_rdata;
    logic             q_full, accept;

    for (genvar g = 0; g < SET_IN_N; g++)
    begin : g_set_map
        localparam int unsigned MAPPED = g % SETS;
        assign set_map[g] = SET_W'(MAPPED);
    end

    // A way outside the stack matches no entry, which leaves the set as a query does.
    always_comb
    begin
        cmd_in.way = way;
        if (mode == lipv_pkg::OP_QUERY || {1'b0, way} >= WAYS_V)
        begin
            cmd_in.op = lipv_pkg::OP_QUERY;
        end
        else
        begin
            cmd_in.op = lipv_pkg::op_t'(mode);
        end
    end

    assign full    = q_full || clearing;
    assign accept  = push && !full;
    assign q_wdata = {set_map[set_number], cmd_in};

    lipv_fifo #(
        .WIDTH (Q_W),
        .DEPTH (lipv_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (cmd_empty)
    );

    assign cmd_head = lipv_pkg::cmd_t'(q_rdata[$bits(lipv_pkg::cmd_t)-1:0]);
    assign cmd_set  = q_rdata[Q_W-1:$bits(lipv_pkg::cmd_t)];

endmodule

`default_nettype wire

// File: rtl/core/lipv_back.sv
// Back part: clears the stacks after reset, then reads, reorders and writes one stack per word.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lipv_back #(
    parameter int unsigned WAYS  = lipv_pkg::WAYS_DEFAULT,
    parameter int unsigned SETS  = lipv_pkg::SETS_DEFAULT,
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lipv_pkg::cfg_t   cfg,
    input  wire logic             cmd_empty,
    input  wire lipv_pkg::cmd_t   cmd_head,
    input  wire logic [SET_W-1:0] cmd_set,
    output logic                  cmd_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output lipv_pkg::res_t        res,
    output logic                  clearing
);

    localparam int unsigned WAY_W   = lipv_pkg::WAY_W;
    localparam int unsigned POS_W   = lipv_pkg::POS_W;
    localparam int unsigned STACK_W = WAYS * WAY_W;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WAYS - 1);

    lipv_pkg::back_state_t state_reg, state_next;
    logic [SET_W-1:0]      clr_reg, clr_next;
    lipv_pkg::cmd_t        cur_cmd_reg;
    logic [SET_W-1:0]      cur_set_reg;

    logic                  ram_we;
    logic [SET_W-1:0]      ram_waddr;
    logic [STACK_W-1:0]    ram_wdata, ram_rdata;
    logic [STACK_W-1:0]    init_stack, new_stack;

    logic [WAY_W-1:0]      old_e [WAYS];
    logic [WAY_W-1:0]      new_e [WAYS];
    logic                  found, move;
    logic [POS_W-1:0]      oldpos, target, raw_target;

    for (genvar g = 0; g < WAYS; g++)
    begin : g_init
        assign init_stack[g*WAY_W +: WAY_W] = WAY_W'(g);
        assign old_e[g] = ram_rdata[g*WAY_W +: WAY_W];
    end

    always_comb
    begin
        found  = 1'b0;
        oldpos = '0;
        if (cur_cmd_reg.op != lipv_pkg::OP_QUERY)
        begin
            for (int i = WAYS - 1; i >= 0; i--)
            begin
                if (old_e[i] == cur_cmd_reg.way)
                begin
                    found  = 1'b1;
                    oldpos = POS_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        unique case (cur_cmd_reg.op)
            lipv_pkg::OP_HIT:   raw_target = cfg.promote[{oldpos, 2'b00} +: POS_W];
            lipv_pkg::OP_FILL:  raw_target = cfg.insert_position;
            lipv_pkg::OP_INVAL: raw_target = LAST_POS;
            lipv_pkg::OP_QUERY: raw_target = oldpos;
            default:            raw_target = oldpos;
        endcase
        target = (raw_target > oldpos) ? oldpos : raw_target;
        if (cur_cmd_reg.op == lipv_pkg::OP_INVAL)
        begin
            target = LAST_POS;
        end
    end

    assign move = found;

    for (genvar g = 0; g < WAYS; g++)
    begin : g_pos
        localparam logic [POS_W-1:0] POS = POS_W'(g);
        logic [WAY_W-1:0] prev_e, next_e;
        if (g == 0)
        begin : g_first
            assign prev_e = old_e[g];
        end
        else
        begin : g_prev
            assign prev_e = old_e[g-1];
        end
        if (g == WAYS - 1)
        begin : g_last
            assign next_e = old_e[g];
        end
        else
        begin : g_next
            assign next_e = old_e[g+1];
        end
        assign new_e[g] = !move                            ? old_e[g]        :
                          (POS == target)                  ? cur_cmd_reg.way :
                          (POS > target && POS <= oldpos)  ? prev_e          :
                          (POS >= oldpos && POS < target)  ? next_e          :
                                                             old_e[g];
        assign new_stack[g*WAY_W +: WAY_W] = new_e[g];
    end

    assign res.victim_way   = new_e[WAYS-1];
    assign res.old_position = found ? oldpos : '0;
    assign clearing         = (state_reg == lipv_pkg::BK_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cur_set_reg;
        ram_wdata  = new_stack;
        unique case (state_reg)
            lipv_pkg::BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = init_stack;
                if (clr_reg == LAST_SET)
                begin
                    state_next = lipv_pkg::BK_FETCH;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            lipv_pkg::BK_FETCH:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop    = 1'b1;
                    state_next = lipv_pkg::BK_EXEC;
                end
            end
            lipv_pkg::BK_EXEC:
            begin
                ram_we     = 1'b1;
                res_push   = 1'b1;
                state_next = lipv_pkg::BK_FETCH;
            end
            default:
            begin
                state_next = lipv_pkg::BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lipv_pkg::BK_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_cmd_reg <= cmd_head;
            cur_set_reg <= cmd_set;
        end
    end

    lipv_ram #(
        .WIDTH (STACK_W),
        .DEPTH (SETS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd_set),
        .rdata (ram_rdata)
    );

    `ASSERT_IMPLY(a_push_has_room, res_push, !res_full, "result pushed into a full queue")
    `ASSERT_IMPLY(a_pop_in_fetch, cmd_pop, !cmd_empty && state_reg == lipv_pkg::BK_FETCH, "bad command pop")
    `ASSERT_NEXT(a_pop_then_exec, cmd_pop, state_reg == lipv_pkg::BK_EXEC && !res_full, "no update after pop")
    `ASSERT_IMPLY(a_clear_quiet, clearing, !cmd_pop && !res_push, "work started during the clearing pass")

endmodule

`default_nettype wire

// File: rtl/core/lru_insertion_promotion_vector_core.sv
// Top level of the recency stack replacement engine with its configuration registers.
//
//   Channel   Handshake          Word
//   request   push / full        mode, set_number, way
//   result    pop / empty        victim_way, old_position
//   config    cfg_write          cfg_index, cfg_data
//
// The back part takes one word at a time: BK_FETCH reads the set's stack from the
// stack RAM and BK_EXEC reorders it, writes it back and queues the result.
// A result is visible at the result port once BK_EXEC has pushed it into the result queue.
// After reset a clearing pass writes the initial order into all SETS stacks, one a
// cycle; full stays high until the pass ends.
// A stalled result side stops the back part; full rises once the command queue fills.
`timescale 1ns / 1ps
`default_nettype none

module lru_insertion_promotion_vector_core #(
    parameter int unsigned WAYS = lipv_pkg::WAYS_DEFAULT,
    parameter int unsigned SETS = lipv_pkg::SETS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [1:0]                     mode,
    input  wire logic [lipv_pkg::SET_IN_W-1:0]  set_number,
    input  wire logic [lipv_pkg::WAY_W-1:0]     way,
    output logic                                empty,
    input  wire logic                           pop,
    output logic      [lipv_pkg::WAY_W-1:0]     victim_way,
    output logic      [lipv_pkg::POS_W-1:0]     old_position,
    input  wire logic                           cfg_write,
    input  wire logic [lipv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lipv_pkg::DATA_W-1:0]    cfg_data
);

    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned RES_W = $bits(lipv_pkg::res_t);

    logic [lipv_pkg::DATA_W-1:0] promote_low_reg;
    logic [lipv_pkg::DATA_W-1:0] promote_high_reg;
    logic [lipv_pkg::POS_W-1:0]  insert_position_reg;
    lipv_pkg::cfg_t              cfg;

    logic             clearing, cmd_pop, cmd_empty;
    lipv_pkg::cmd_t   cmd_head;
    logic [SET_W-1:0] cmd_set;
    logic             res_push, res_full;
    lipv_pkg::res_t   res_in, res_head;
    logic [RES_W-1:0] res_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promote_low_reg     <= lipv_pkg::PROMOTE_LOW_RESET;
            promote_high_reg    <= lipv_pkg::PROMOTE_HIGH_RESET;
            insert_position_reg <= lipv_pkg::INSERT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lipv_pkg::REG_PROMOTE_LOW:     promote_low_reg  <= cfg_data;
                lipv_pkg::REG_PROMOTE_HIGH:    promote_high_reg <= cfg_data;
                lipv_pkg::REG_INSERT_POSITION:
                    insert_position_reg <= cfg_data[lipv_pkg::POS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.promote         = {promote_high_reg, promote_low_reg};
    assign cfg.insert_position = insert_position_reg;

    lipv_front #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .mode       (mode),
        .set_number (set_number),
        .way        (way),
        .clearing   (clearing),
        .full       (full),
        .cmd_pop    (cmd_pop),
        .cmd_empty  (cmd_empty),
        .cmd_head   (cmd_head),
        .cmd_set    (cmd_set)
    );

    lipv_back #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_set   (cmd_set),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .clearing  (clearing)
    );

    lipv_fifo #(
        .WIDTH (RES_W),
        .DEPTH (lipv_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_head     = lipv_pkg::res_t'(res_rdata);
    assign victim_way   = res_head.victim_way;
    assign old_position = res_head.old_position;

endmodule

`default_nettype wire

// File: verif/lru_insertion_promotion_vector_core_tb.sv
// Self-checking testbench for the recency stack replacement engine.
`timescale 1ns / 1ps
`default_nettype none

module lru_insertion_promotion_vector_core_tb;

    localparam int QUIET_LIMIT = 4000;
    localparam int SEGMENT_WORDS = 58;

    typedef struct {
        lipv_pkg::op_t                  op;
        logic [5:0]                     set_sel;
        logic [lipv_pkg::WAY_W-1:0]     way_sel;
        lipv_pkg::res_t                 res;
    } lookup_t;

    class recency_scoreboard;
        logic [63:0]                 stacks [64];
        logic [lipv_pkg::DATA_W-1:0] promote_lo;
        logic [lipv_pkg::DATA_W-1:0] promote_hi;
        logic [lipv_pkg::POS_W-1:0]  insert_pos;
        lookup_t                     expected_q [$];
        int                          mismatches;
        int                          results_checked;

        function new();
            logic [63:0] init_order;
            init_order = '0;
            for (int i = 0; i < 16; i++)
            begin
                init_order[4*i +: 4] = 4'(i);
            end
            foreach (stacks[s])
            begin
                stacks[s] = init_order;
            end
            promote_lo = lipv_pkg::PROMOTE_LOW_RESET;
            promote_hi = lipv_pkg::PROMOTE_HIGH_RESET;
            insert_pos = lipv_pkg::INSERT_RESET;
            mismatches = 0;
            results_checked = 0;
        endfunction

        function void write_register(logic [lipv_pkg::CFG_IDX_W-1:0] idx,
                                     logic [lipv_pkg::DATA_W-1:0] data);
            case (idx)
                lipv_pkg::REG_PROMOTE_LOW:     promote_lo = data;
                lipv_pkg::REG_PROMOTE_HIGH:    promote_hi = data;
                lipv_pkg::REG_INSERT_POSITION: insert_pos = data[lipv_pkg::POS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_word(lipv_pkg::op_t op, logic [5:0] set_sel,
                                logic [lipv_pkg::WAY_W-1:0] way_sel);
            logic [63:0]                    st;
            logic [lipv_pkg::PROMOTE_W-1:0] promote;
            lookup_t                        item;
            int                             pos;
            int                             tgt;
            int                             i;
            bit                             found;
            st = stacks[set_sel];
            promote = {promote_hi, promote_lo};
            found = 1'b0;
            pos = 0;
            if (op != lipv_pkg::OP_QUERY)
            begin
                for (i = 0; i < 16; i++)
                begin
                    if (!found && st[4*i +: 4] == way_sel)
                    begin
                        found = 1'b1;
                        pos = i;
                    end
                end
            end
            if (found)
            begin
                case (op)
                    lipv_pkg::OP_HIT:  tgt = int'(promote[4*pos +: 4]);
                    lipv_pkg::OP_FILL: tgt = int'(insert_pos);
                    default:           tgt = 15;
                endcase
                if (op != lipv_pkg::OP_INVAL && tgt > pos)
                begin
                    tgt = pos;
                end
                if (tgt < pos)
                begin
                    for (i = pos; i > tgt; i--)
                    begin
                        st[4*i +: 4] = st[4*(i-1) +: 4];
                    end
                end
                else
                begin
                    for (i = pos; i < tgt; i++)
                    begin
                        st[4*i +: 4] = st[4*(i+1) +: 4];
                    end
                end
                st[4*tgt +: 4] = way_sel;
                stacks[set_sel] = st;
            end
            item.op = op;
            item.set_sel = set_sel;
            item.way_sel = way_sel;
            item.res.victim_way = st[63:60];
            item.res.old_position = found ? 4'(pos) : 4'd0;
            expected_q.push_back(item);
        endfunction

        function void check_result(logic [lipv_pkg::WAY_W-1:0] victim,
                                   logic [lipv_pkg::POS_W-1:0] old_pos);
            lookup_t item;
            results_checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected result victim=%0d old_position=%0d",
                             victim, old_pos);
                end
            end
            else
            begin
                item = expected_q.pop_front();
                if (victim !== item.res.victim_way || old_pos !== item.res.old_position)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: %s set %0d way %0d: victim exp %0d got %0d, %s",
                                 item.op.name(), item.set_sel, item.way_sel,
                                 item.res.victim_way, victim,
                                 $sformatf("old_position exp %0d got %0d",
                                           item.res.old_position, old_pos));
                    end
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [1:0]                     mode = 2'd0;
    logic [lipv_pkg::SET_IN_W-1:0]  set_number = '0;
    logic [lipv_pkg::WAY_W-1:0]     way = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [lipv_pkg::WAY_W-1:0]     victim_way;
    logic [lipv_pkg::POS_W-1:0]     old_position;
    logic                           cfg_write = 1'b0;
    logic [lipv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lipv_pkg::DATA_W-1:0]    cfg_data = '0;

    recency_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent = 0;
    int settings_loaded = 0;

    lru_insertion_promotion_vector_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .set_number   (set_number),
        .way          (way),
        .empty        (empty),
        .pop          (pop),
        .victim_way   (victim_way),
        .old_position (old_position),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                sb.write_register(cfg_index, cfg_data);
            end
            if (push && !full)
            begin
                sb.note_word(lipv_pkg::op_t'(mode), set_number, way);
            end
            if (pop && !empty)
            begin
                sb.check_result(victim_way, old_position);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("ERROR: no traffic for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_word(lipv_pkg::op_t op, logic [5:0] set_sel,
                             logic [lipv_pkg::WAY_W-1:0] way_sel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        mode <= op;
        set_number <= set_sel;
        way <= way_sel;
        do
        begin
            @(posedge clk);
        end
        while (full);
        words_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(logic [lipv_pkg::DATA_W-1:0] lo,
                                 logic [lipv_pkg::DATA_W-1:0] hi,
                                 logic [lipv_pkg::POS_W-1:0] ins);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= lipv_pkg::REG_PROMOTE_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= lipv_pkg::REG_PROMOTE_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_index <= lipv_pkg::REG_INSERT_POSITION;
        cfg_data <= {{(lipv_pkg::DATA_W-lipv_pkg::POS_W){1'b0}}, ins};
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_word();
        int            r;
        lipv_pkg::op_t op;
        logic [5:0]    set_sel;
        r = $urandom_range(99);
        if (r < 40)
        begin
            op = lipv_pkg::OP_HIT;
        end
        else if (r < 65)
        begin
            op = lipv_pkg::OP_FILL;
        end
        else if (r < 85)
        begin
            op = lipv_pkg::OP_INVAL;
        end
        else
        begin
            op = lipv_pkg::OP_QUERY;
        end
        if ($urandom_range(99) < 70)
        begin
            case ($urandom_range(3))
                0:       set_sel = 6'd0;
                1:       set_sel = 6'd63;
                2:       set_sel = 6'd21;
                default: set_sel = 6'd42;
            endcase
        end
        else
        begin
            set_sel = 6'($urandom_range(63));
        end
        send_word(op, set_sel, 4'($urandom_range(15)));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: promotion targets never lie below the current position.
        send_word(lipv_pkg::OP_QUERY, 6'd0, 4'd15);
        send_word(lipv_pkg::OP_HIT, 6'd0, 4'd15);
        send_word(lipv_pkg::OP_HIT, 6'd0, 4'd0);
        send_word(lipv_pkg::OP_HIT, 6'd0, 4'd10);
        send_word(lipv_pkg::OP_FILL, 6'd0, 4'd14);
        send_word(lipv_pkg::OP_FILL, 6'd63, 4'd3);
        send_word(lipv_pkg::OP_FILL, 6'd63, 4'd15);
        send_word(lipv_pkg::OP_INVAL, 6'd63, 4'd0);
        send_word(lipv_pkg::OP_INVAL, 6'd63, 4'd0);
        send_word(lipv_pkg::OP_INVAL, 6'd1, 4'd15);
        send_word(lipv_pkg::OP_QUERY, 6'd63, 4'd0);
        send_word(lipv_pkg::OP_HIT, 6'd42, 4'd4);
        send_word(lipv_pkg::OP_HIT, 6'd21, 4'd12);

        // Every target at the least recent position, so hits and fills leave ways in place.
        load_settings('1, '1, 4'd15);
        send_word(lipv_pkg::OP_HIT, 6'd0, 4'd5);
        send_word(lipv_pkg::OP_FILL, 6'd0, 4'd9);
        send_word(lipv_pkg::OP_HIT, 6'd0, 4'd15);
        send_word(lipv_pkg::OP_INVAL, 6'd0, 4'd5);

        // Every target at the most recent position.
        load_settings('0, '0, 4'd0);
        send_word(lipv_pkg::OP_HIT, 6'd63, 4'd8);
        send_word(lipv_pkg::OP_FILL, 6'd63, 4'd15);
        send_word(lipv_pkg::OP_HIT, 6'd0, 4'd0);
        send_word(lipv_pkg::OP_QUERY, 6'd42, 4'd7);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                case ((seg + phase) % 4)
                    0: load_settings($urandom(), $urandom(), 4'($urandom_range(15)));
                    1: load_settings('0, '0, 4'd0);
                    2: load_settings('1, '1, 4'd15);
                    default: load_settings(lipv_pkg::PROMOTE_LOW_RESET,
                                           lipv_pkg::PROMOTE_HIGH_RESET,
                                           lipv_pkg::INSERT_RESET);
                endcase
                repeat (SEGMENT_WORDS) random_word();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d words under %0d register settings in three flow-control phases.",
                 words_sent, settings_loaded);
        $display("Checked %0d results, %0d mismatches.", sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/lipv_pkg.sv
rtl/core/lipv_ram.sv
rtl/core/lipv_fifo.sv
rtl/core/lipv_front.sv
rtl/core/lipv_back.sv
rtl/core/lru_insertion_promotion_vector_core.sv
verif/lru_insertion_promotion_vector_core_tb.sv
